[hw/rtl/mpfr_pkg.sv]
`timescale 1ns / 1ps

package mpfr_pkg;

  // Sizes of the pattern set, window and replacement
  localparam int NumPatterns = 4;
  localparam int PatLen      = 8;
  localparam int RepLen      = 8;
  localparam int WinDepth    = PatLen;
  localparam int RegBytes    = 8;
  localparam int LenW        = $clog2(PatLen + 1);
  localparam int RepIdxW     = $clog2(RepLen);
  localparam int WinIdxW     = $clog2(WinDepth);
  localparam int PatIdxW     = $clog2(NumPatterns);

  // Input queue between the front and the back
  localparam int QueueDepth  = 4;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);

  // Register port
  localparam int CfgDataW    = 64;
  localparam int CfgAddrW    = 6;
  localparam int RegIdxW     = 3;

  // Register indexes
  localparam logic [RegIdxW-1:0] RegPatA   = 3'd0;
  localparam logic [RegIdxW-1:0] RegPatB   = 3'd1;
  localparam logic [RegIdxW-1:0] RegPatC   = 3'd2;
  localparam logic [RegIdxW-1:0] RegPatD   = 3'd3;
  localparam logic [RegIdxW-1:0] RegPatLen = 3'd4;
  localparam logic [RegIdxW-1:0] RegRep    = 3'd5;
  localparam logic [RegIdxW-1:0] RegRepLen = 3'd6;

  // Decision codes for the window head
  localparam logic [1:0] DecNone  = 2'd0;
  localparam logic [1:0] DecMatch = 2'd1;
  localparam logic [1:0] DecWait  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [NumPatterns-1:0][RegBytes*8-1:0] pattern;
    logic [4*NumPatterns-1:0]               pattern_lengths;
    logic [RegBytes*8-1:0]                  replacement;
    logic [3:0]                             replacement_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [PatIdxW-1:0] which;
  } dec_t;

  // Clamp a length nibble to the pattern bound
  function automatic logic [LenW-1:0] pat_len(input logic [3:0] n);
    return (n > 4'(PatLen)) ? LenW'(PatLen) : LenW'(n);
  endfunction

  // Clamp the replacement length to its bound
  function automatic logic [LenW-1:0] rep_len(input logic [3:0] n);
    return (n > 4'(RepLen)) ? LenW'(RepLen) : LenW'(n);
  endfunction

  // Classify the window head: match, no match, or wait for more bytes
  function automatic dec_t decide(input logic [WinDepth-1:0][7:0] win,
                                  input logic [LenW-1:0] fill,
                                  input logic last,
                                  input cfg_t cfg);
    dec_t d;
    logic done;
    logic same;
    logic [LenW-1:0] len;
    d.kind  = DecNone;
    d.which = '0;
    done    = 1'b0;
    for (int i = 0; i < NumPatterns; i++) begin
      len  = pat_len(cfg.pattern_lengths[4*i +: 4]);
      same = 1'b1;
      for (int k = 0; k < PatLen; k++) begin
        if ((LenW'(k) < len) && (LenW'(k) < fill) &&
            (win[k] != cfg.pattern[i][8*k +: 8])) begin
          same = 1'b0;
        end
      end
      if (!done && (len != '0) && same) begin
        if (len <= fill) begin
          d.kind  = DecMatch;
          d.which = PatIdxW'(i);
          done    = 1'b1;
        end else if (!last) begin
          d.kind = DecWait;
          done   = 1'b1;
        end
      end
    end
    return d;
  endfunction

endpackage

[hw/rtl/mpfr_if.sv]
`timescale 1ns / 1ps

// Source text channel
interface mpfr_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

// Rewritten text channel
interface mpfr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       output_end;

  modport source (output valid, output out_byte, output byte_present,
                  output output_end, input ready);
  modport sink (input valid, input out_byte, input byte_present,
                input output_end, output ready);
endinterface

[hw/rtl/multi_pattern_find_replace_unit.sv]
`timescale 1ns / 1ps

// Multi-pattern find and replace on a byte stream.
// The item channel takes one source byte per beat, with string_end on the
// last byte of a string. The result channel gives the rewritten bytes, one
// per beat; output_end marks the last beat of a string, and a string that
// rewrites to nothing gives one beat with byte_present low.
// Patterns, lengths and the replacement sit in registers on the APB port
// (64-bit data, register i at byte address 8*i); write them while idle.
// A four-beat input queue feeds the window engine, so items keep arriving
// while a result waits. While the receiver takes results, the engine makes
// one window decision per cycle and puts out at most one byte: plain text
// streams at one byte per cycle, a match gives its replacement one byte
// at a time (an empty one still takes a step), a byte held as a possible
// match prefix leaves when it is decided, and each string end adds a
// closing step. An accepted byte passes the queue and the output register.
// When the receiver stalls, the output register holds its beat, the engine
// freezes and the queue fills, then ready drops on the item channel.
// Reset clears the queue, the window, the registers and the output.

module multi_pattern_find_replace_unit (
  input  logic                          clk,
  input  logic                          rst,
  mpfr_item_if.sink                     item,
  mpfr_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpfr_pkg::CfgAddrW-1:0] paddr,
  input  logic [mpfr_pkg::CfgDataW-1:0] pwdata,
  output logic [mpfr_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  mpfr_pkg::cfg_t        cfg;
  mpfr_pkg::queue_head_t head;
  logic                  pop;

  mpfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpfr_front u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .head (head),
    .pop  (pop)
  );

  mpfr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

[hw/rtl/mpfr_cfg.sv]
`timescale 1ns / 1ps

module mpfr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpfr_pkg::CfgAddrW-1:0] paddr,
  input  logic [mpfr_pkg::CfgDataW-1:0] pwdata,
  output logic [mpfr_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output mpfr_pkg::cfg_t                cfg
);

  logic                                wr_en;
  logic [mpfr_pkg::RegIdxW-1:0]        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[mpfr_pkg::CfgAddrW-1:mpfr_pkg::CfgAddrW-mpfr_pkg::RegIdxW];

  // Write registers on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        mpfr_pkg::RegPatA:   cfg.pattern[0] <= pwdata;
        mpfr_pkg::RegPatB:   cfg.pattern[1] <= pwdata;
        mpfr_pkg::RegPatC:   cfg.pattern[2] <= pwdata;
        mpfr_pkg::RegPatD:   cfg.pattern[3] <= pwdata;
        mpfr_pkg::RegPatLen: cfg.pattern_lengths <= pwdata[4*mpfr_pkg::NumPatterns-1:0];
        mpfr_pkg::RegRep:    cfg.replacement <= pwdata;
        mpfr_pkg::RegRepLen: cfg.replacement_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      mpfr_pkg::RegPatA:   prdata = cfg.pattern[0];
      mpfr_pkg::RegPatB:   prdata = cfg.pattern[1];
      mpfr_pkg::RegPatC:   prdata = cfg.pattern[2];
      mpfr_pkg::RegPatD:   prdata = cfg.pattern[3];
      mpfr_pkg::RegPatLen: prdata = mpfr_pkg::CfgDataW'(cfg.pattern_lengths);
      mpfr_pkg::RegRep:    prdata = cfg.replacement;
      mpfr_pkg::RegRepLen: prdata = mpfr_pkg::CfgDataW'(cfg.replacement_length);
      default:             prdata = '0;
    endcase
  end

endmodule

[hw/rtl/mpfr_front.sv]
`timescale 1ns / 1ps

module mpfr_front (
  input  logic                  clk,
  input  logic                  rst,
  mpfr_item_if.sink             item,
  output mpfr_pkg::queue_head_t head,
  input  logic                  pop
);

  mpfr_pkg::item_t                 queue [mpfr_pkg::QueueDepth];
  logic [mpfr_pkg::QPtrW-1:0]      wr_ptr;
  logic [mpfr_pkg::QPtrW-1:0]      rd_ptr;
  logic [mpfr_pkg::QCntW-1:0]      count;
  logic                            push;
  logic                            pull;

  assign item.ready = (count != mpfr_pkg::QCntW'(mpfr_pkg::QueueDepth));
  assign push       = item.valid && item.ready;
  assign pull       = pop && head.valid;

  assign head.valid = (count != '0);
  assign head.item  = queue[rd_ptr];

  // Store accepted beats
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{in_byte: item.in_byte, string_end: item.string_end};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pull) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pull})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/mpfr_back.sv]
`timescale 1ns / 1ps

module mpfr_back (
  input  logic                  clk,
  input  logic                  rst,
  input  mpfr_pkg::cfg_t        cfg,
  input  mpfr_pkg::queue_head_t head,
  output logic                  pop,
  mpfr_result_if.source         result
);

  localparam int WD = mpfr_pkg::WinDepth;
  localparam int LW = mpfr_pkg::LenW;

  // Window and step state
  logic [WD-1:0][7:0]               win;
  logic [WD-1:0][7:0]               win_next;
  logic [LW-1:0]                    fill;
  logic [LW-1:0]                    fill_next;
  logic                             fin;
  logic [mpfr_pkg::RepIdxW-1:0]     rep_idx;
  logic [mpfr_pkg::RepIdxW-1:0]     rep_idx_next;
  logic [7:0]                       hold_byte;
  logic                             hold_valid;

  // Output register
  logic                             out_valid;
  logic [7:0]                       out_byte;
  logic                             out_present;
  logic                             out_end;
  logic                             out_wr;
  logic [7:0]                       out_byte_next;
  logic                             out_present_next;
  logic                             out_end_next;

  // Decision datapath
  logic                             adv;
  logic [WD-1:0][7:0]               win_app;
  logic [WD-1:0][7:0]               eff_win;
  logic [LW-1:0]                    eff_fill;
  logic                             eff_last;
  mpfr_pkg::dec_t                   dec_cur;
  mpfr_pkg::dec_t                   dec_new;
  mpfr_pkg::dec_t                   eff_dec;
  logic                             resting;
  logic                             take;
  logic                             act_cur;
  logic                             do_act;
  logic                             complete;
  logic [LW-1:0]                    rl;
  logic [LW-1:0]                    plen;
  logic                             last_rep;
  logic                             emit_valid;
  logic [7:0]                       emit_byte;
  logic [LW-1:0]                    drop_n;
  logic [LW:0]                      src_idx;

  assign adv = !out_valid || result.ready;

  // Window with the queue head appended
  always_comb begin
    for (int k = 0; k < WD; k++) begin
      win_app[k] = (LW'(k) == fill) ? head.item.in_byte : win[k];
    end
  end

  assign dec_cur = mpfr_pkg::decide(win, fill, fin, cfg);
  assign dec_new = mpfr_pkg::decide(win_app, fill + 1'b1, head.item.string_end, cfg);

  // Step control: rest, act on the window, take a beat, or close the string
  assign resting  = !fin && ((fill == '0) || (dec_cur.kind == mpfr_pkg::DecWait));
  assign take     = adv && resting && head.valid;
  assign act_cur  = adv && (fill != '0) && !resting;
  assign complete = adv && fin && (fill == '0);
  assign pop      = take;

  assign eff_win  = take ? win_app : win;
  assign eff_fill = take ? fill + 1'b1 : fill;
  assign eff_dec  = take ? dec_new : dec_cur;
  assign eff_last = take ? head.item.string_end : fin;
  assign do_act   = act_cur || (take && (dec_new.kind != mpfr_pkg::DecWait));

  assign rl   = mpfr_pkg::rep_len(cfg.replacement_length);
  assign plen = mpfr_pkg::pat_len(cfg.pattern_lengths[4*eff_dec.which +: 4]);

  // Emit at most one byte and pick how far the window drops
  always_comb begin
    if (eff_dec.kind == mpfr_pkg::DecMatch) begin
      last_rep     = (rl == '0) || (LW'(rep_idx) == rl - 1'b1);
      emit_valid   = (rl != '0);
      emit_byte    = cfg.replacement[8*rep_idx +: 8];
      drop_n       = last_rep ? plen : '0;
      rep_idx_next = last_rep ? '0 : rep_idx + 1'b1;
    end else begin
      last_rep     = 1'b1;
      emit_valid   = 1'b1;
      emit_byte    = eff_win[0];
      drop_n       = LW'(1);
      rep_idx_next = '0;
    end
  end

  // Shift the window down by the dropped count
  always_comb begin
    src_idx = '0;
    for (int k = 0; k < WD; k++) begin
      src_idx = (LW + 1)'(k) + (LW + 1)'(drop_n);
      if (do_act && src_idx < (LW + 1)'(WD)) begin
        win_next[k] = eff_win[src_idx[mpfr_pkg::WinIdxW-1:0]];
      end else begin
        win_next[k] = eff_win[k];
      end
    end
    fill_next = do_act ? eff_fill - drop_n : eff_fill;
  end

  // Route results: straight out, or through the hold slot on the last step
  always_comb begin
    out_wr           = 1'b0;
    out_byte_next    = out_byte;
    out_present_next = out_present;
    out_end_next     = out_end;
    if (complete) begin
      out_wr           = 1'b1;
      out_byte_next    = hold_valid ? hold_byte : 8'd0;
      out_present_next = hold_valid;
      out_end_next     = 1'b1;
    end else if (do_act && emit_valid) begin
      if (!eff_last) begin
        out_wr           = 1'b1;
        out_byte_next    = emit_byte;
        out_present_next = 1'b1;
        out_end_next     = 1'b0;
      end else if (hold_valid) begin
        out_wr           = 1'b1;
        out_byte_next    = hold_byte;
        out_present_next = 1'b1;
        out_end_next     = 1'b0;
      end
    end
  end

  // Window payload
  always_ff @(posedge clk) begin
    if (take || do_act) begin
      win <= win_next;
    end
    if (do_act && emit_valid && eff_last) begin
      hold_byte <= emit_byte;
    end
    if (out_wr) begin
      out_byte    <= out_byte_next;
      out_present <= out_present_next;
      out_end     <= out_end_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      fin        <= 1'b0;
      rep_idx    <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take || do_act) begin
        fill <= fill_next;
      end
      if (do_act) begin
        rep_idx <= rep_idx_next;
      end
      if (take) begin
        fin <= head.item.string_end;
      end else if (complete) begin
        fin <= 1'b0;
      end
      if (complete) begin
        hold_valid <= 1'b0;
      end else if (do_act && emit_valid && eff_last) begin
        hold_valid <= 1'b1;
      end
      if (out_wr) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.out_byte     = out_byte;
  assign result.byte_present = out_present;
  assign result.output_end   = out_end;

  // Checks
  a_hold_in_last: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> fin)
    else $error("hold slot used outside the last step of a string");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LW'(WD))
    else $error("window fill beyond depth");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> $stable(fill) && $stable(rep_idx) && $stable(fin))
    else $error("window moved while the result beat was stalled");

  a_rest_no_rep: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (rep_idx == '0))
    else $error("replacement in progress with an empty window");

endmodule

[verif/multi_pattern_find_replace_unit_tb.sv]
`timescale 1ns / 1ps

module multi_pattern_find_replace_unit_tb;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 16;
  localparam int LongHold     = 300;
  localparam int Phases       = 8;
  localparam int PhaseItems   = 40;
  localparam int DirCount     = 25;

  localparam logic [mpfr_pkg::RegIdxW-1:0] RegUnused    = 3'd7;
  localparam logic [3:0]                   KeepSettings = 4'hF;
  localparam logic [7:0]                   Bar          = 8'h7C;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       output_end;
  } beat_t;

  typedef struct packed {
    logic [3:0] setting;
    logic [7:0] in_byte;
    logic       string_end;
    logic       typed;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       output_end;
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [mpfr_pkg::CfgAddrW-1:0] paddr;
  logic [mpfr_pkg::CfgDataW-1:0] pwdata;
  logic [mpfr_pkg::CfgDataW-1:0] prdata;
  logic                          pready;

  mpfr_item_if   item_ch ();
  mpfr_result_if result_ch ();

  multi_pattern_find_replace_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block: registers and the undecided window
  mpfr_pkg::cfg_t shadow;
  logic [7:0]     win_bytes [mpfr_pkg::WinDepth];
  int unsigned    win_fill;
  beat_t          step_beats [$];
  beat_t          awaited_beats [$];

  int   mismatches  = 0;
  int   cycle_count = 0;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  logic hold_req    = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  mpfr_pkg::cfg_t dir_settings [4];
  dir_row_t dir_rows [DirCount] = '{
    // after reset every pattern is off: bytes pass straight through
    '{KeepSettings, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
    '{KeepSettings, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1},
    // lower pattern wins at one position, then a pending prefix at the end
    '{4'd0, 8'h78, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h61, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h62, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h63, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h61, 1'b1, 1'b1, 8'h61, 1'b1, 1'b1},
    '{KeepSettings, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    // oversized lengths clamp to eight bytes
    '{4'd1, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h04, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h08, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h10, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h40, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h80, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
    // deletion: an empty rewritten string gives the bare end marker
    '{4'd2, 8'h7A, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
    '{KeepSettings, 8'h71, 1'b0, 1'b1, 8'h71, 1'b1, 1'b0},
    '{KeepSettings, 8'h7A, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
    '{KeepSettings, 8'h71, 1'b0, 1'b1, 8'h71, 1'b1, 1'b0},
    // new settings in the middle of a string
    '{4'd3, 8'h7A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h7A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{KeepSettings, 8'h7A, 1'b1, 1'b1, 8'h7A, 1'b1, 1'b1}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic mpfr_pkg::cfg_t make_cfg(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] c, input logic [63:0] d,
                                              input logic [15:0] lens,
                                              input logic [63:0] rep,
                                              input logic [3:0] rep_n);
    mpfr_pkg::cfg_t s;
    s.pattern[0]         = a;
    s.pattern[1]         = b;
    s.pattern[2]         = c;
    s.pattern[3]         = d;
    s.pattern_lengths    = lens;
    s.replacement        = rep;
    s.replacement_length = rep_n;
    return s;
  endfunction

  // Effective length of one pattern, clamped to eight bytes
  function automatic int unsigned span(input int i);
    logic [3:0] n;
    n = shadow.pattern_lengths[4*i +: 4];
    return (n > 4'd8) ? 8 : n;
  endfunction

  // Classify the window head against the patterns in priority order
  function automatic logic [1:0] judge_head(input logic last, output int hit);
    int unsigned len;
    int unsigned m;
    logic        same;
    hit = 0;
    for (int i = 0; i < mpfr_pkg::NumPatterns; i++) begin
      len = span(i);
      if (len == 0) continue;
      m    = (len < win_fill) ? len : win_fill;
      same = 1'b1;
      for (int k = 0; k < m; k++) begin
        if (win_bytes[k] != shadow.pattern[i][8*k +: 8]) same = 1'b0;
      end
      if (!same) continue;
      if (len <= win_fill) begin
        hit = i;
        return mpfr_pkg::DecMatch;
      end
      if (!last) return mpfr_pkg::DecWait;
    end
    return mpfr_pkg::DecNone;
  endfunction

  function automatic void shift_out(input int unsigned n);
    if (n > win_fill) n = win_fill;
    for (int k = 0; k < win_fill - n; k++) win_bytes[k] = win_bytes[k + n];
    win_fill -= n;
  endfunction

  // Rewrite one source byte into the beats it releases
  function automatic void rewrite_byte(input logic [7:0] b, input logic last);
    logic [1:0]  verdict;
    int          hit;
    int unsigned rl;
    step_beats.delete();
    if (win_fill < mpfr_pkg::WinDepth) begin
      win_bytes[win_fill] = b;
      win_fill++;
    end
    while (win_fill > 0) begin
      verdict = judge_head(last, hit);
      if (verdict == mpfr_pkg::DecWait) break;
      if (verdict == mpfr_pkg::DecMatch) begin
        rl = (shadow.replacement_length > 4'd8) ? 8 : shadow.replacement_length;
        for (int k = 0; k < rl; k++)
          step_beats.push_back(beat_t'{shadow.replacement[8*k +: 8], 1'b1, 1'b0});
        shift_out(span(hit));
      end else begin
        step_beats.push_back(beat_t'{win_bytes[0], 1'b1, 1'b0});
        shift_out(1);
      end
    end
    if (last) begin
      win_fill = 0;
      if (step_beats.size() == 0) step_beats.push_back(beat_t'{8'h00, 1'b0, 1'b1});
      else step_beats[step_beats.size() - 1].output_end = 1'b1;
    end
  endfunction

  function automatic void note_write(input logic [mpfr_pkg::RegIdxW-1:0] idx,
                                     input logic [63:0] v);
    unique case (idx)
      mpfr_pkg::RegPatA, mpfr_pkg::RegPatB, mpfr_pkg::RegPatC, mpfr_pkg::RegPatD:
        shadow.pattern[idx[1:0]] = v;
      mpfr_pkg::RegPatLen: shadow.pattern_lengths = v[15:0];
      mpfr_pkg::RegRep: shadow.replacement = v;
      mpfr_pkg::RegRepLen: shadow.replacement_length = v[3:0];
      default: ;
    endcase
  endfunction

  function automatic logic [3:0] pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'($urandom_range(9, 15));
    if (r == 2) return 4'd8;
    return 4'($urandom_range(1, 4));
  endfunction

  // Mostly a three-letter alphabet so that matches are frequent
  function automatic mpfr_pkg::cfg_t random_settings();
    mpfr_pkg::cfg_t s;
    logic wide;
    wide = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < mpfr_pkg::NumPatterns; i++) begin
      for (int k = 0; k < mpfr_pkg::RegBytes; k++)
        s.pattern[i][8*k +: 8] = wide ? 8'($urandom_range(0, 255))
                                      : 8'(8'h61 + $urandom_range(0, 2));
      s.pattern_lengths[4*i +: 4] = pick_len();
    end
    for (int k = 0; k < mpfr_pkg::RegBytes; k++)
      s.replacement[8*k +: 8] = 8'($urandom_range(0, 255));
    s.replacement_length = pick_len();
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Setup and access phase, then the port returns to idle
  task automatic write_reg(input logic [mpfr_pkg::RegIdxW-1:0] idx, input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    note_write(idx, v);
    @(posedge clk);
  endtask

  task automatic load_settings(input mpfr_pkg::cfg_t s);
    write_reg(mpfr_pkg::RegPatA, s.pattern[0]);
    write_reg(mpfr_pkg::RegPatB, s.pattern[1]);
    write_reg(mpfr_pkg::RegPatC, s.pattern[2]);
    write_reg(mpfr_pkg::RegPatD, s.pattern[3]);
    write_reg(mpfr_pkg::RegPatLen, {48'h0, s.pattern_lengths});
    write_reg(mpfr_pkg::RegRep, s.replacement);
    write_reg(mpfr_pkg::RegRepLen, {60'h0, s.replacement_length});
    // unmapped register: the write must be ignored
    write_reg(RegUnused, {$urandom, $urandom});
  endtask

  // Hold the sender until every awaited beat is in and the queue is empty
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input beat_t want);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.in_byte    <= b;
    item_ch.string_end <= last;
    do @(posedge clk); while (!item_ch.ready);
    rewrite_byte(b, last);
    if (typed) awaited_beats.push_back(want);
    else foreach (step_beats[i]) awaited_beats.push_back(step_beats[i]);
  endtask

  // Build a string from whole and broken pattern copies plus noise
  task automatic send_text(output int n);
    logic [7:0] text [$];
    int         len;
    int         r;
    int         p;
    int         k;
    int         cut;
    len = $urandom_range(1, 24);
    while (text.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        p   = $urandom_range(0, mpfr_pkg::NumPatterns - 1);
        k   = (span(p) == 0) ? 1 : span(p);
        cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, k) : k;
        for (int j = 0; j < cut; j++) text.push_back(shadow.pattern[p][8*j +: 8]);
      end else if (r < 85) begin
        text.push_back(shadow.pattern[$urandom_range(0, 3)][8*$urandom_range(0, 7) +: 8]);
      end else begin
        text.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1, 1'b0, '0);
    n = text.size();
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen       <= hold_req;
      hold_left       <= LongHold;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each result beat with the oldest awaited one
  always @(posedge clk) begin
    beat_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (awaited_beats.size() == 0) begin
        report_mismatch($sformatf("beat %02h with none awaited", result_ch.out_byte));
      end else begin
        want = awaited_beats.pop_front();
        if (result_ch.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h",
                                    result_ch.out_byte, want.out_byte));
        if (result_ch.byte_present !== want.byte_present)
          report_mismatch($sformatf("byte_present %b, want %b",
                                    result_ch.byte_present, want.byte_present));
        if (result_ch.output_end !== want.output_end)
          report_mismatch($sformatf("output_end %b, want %b",
                                    result_ch.output_end, want.output_end));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    int       sent;
    int       n;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.in_byte    <= '0;
    item_ch.string_end <= 1'b0;
    shadow   = '0;
    win_fill = 0;
    dir_settings[0] = make_cfg(64'h6261, 64'h636261, '1, 64'h62, 16'h1832,
                               {56'h0, Bar}, 4'd1);
    dir_settings[1] = make_cfg(64'h8040201008040201, '0, '0, '0, 16'hFFFF,
                               64'hFEDCBA9876543210, 4'hF);
    dir_settings[2] = make_cfg(64'h7A, '1, '1, '1, 16'h0001, '1, 4'd0);
    dir_settings[3] = make_cfg(64'h7A7A, '0, '0, '0, 16'h0002, {56'h0, Bar}, 4'd1);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int r = 0; r < DirCount; r++) begin
      row = dir_rows[r];
      if (row.setting != KeepSettings) begin
        drain_results();
        load_settings(dir_settings[row.setting]);
      end
      send_byte(row.in_byte, row.string_end, row.typed,
                beat_t'{row.out_byte, row.byte_present, row.output_end});
    end

    // Random strings under random settings, one idling mode per phase
    for (int ph = 0; ph < Phases; ph++) begin
      drain_results();
      unique case (ph % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 50; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 50; end
        default: begin idle_pct = 13; stall_pct <= 13; end
      endcase
      load_settings(random_settings());
      if (ph == 4) hold_req <= ~hold_req;
      sent = 0;
      while (sent < PhaseItems) begin
        send_text(n);
        sent += n;
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mpfr_pkg.sv
hw/rtl/mpfr_if.sv
hw/rtl/mpfr_cfg.sv
hw/rtl/mpfr_front.sv
hw/rtl/mpfr_back.sv
hw/rtl/multi_pattern_find_replace_unit.sv
verif/multi_pattern_find_replace_unit_tb.sv
